// ===== src/assert_macros.svh =====
// assertion helpers for the rgb565 to bmp24 stream unit
// expects a clock named clock and a reset named reset in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(lbl, cond, msg) \
   `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== src/rgb2bmp_pkg.sv =====
// shared types, constants, side clamp and header byte functions for the rgb565 to bmp24 unit
// no dependencies
`default_nettype none

package rgb2bmp_pkg;

   localparam int unsigned SIDE_W            = 12;
   localparam int unsigned COUNT_W           = 11;
   localparam logic [SIDE_W-1:0] MAX_SIDE    = 12'd2048;
   localparam logic [SIDE_W-1:0] WIDTH_RESET = 12'd800;
   localparam logic [SIDE_W-1:0] HEIGHT_RESET = 12'd480;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // byte positions within the sequence of one pixel job
   localparam int unsigned IDX_W             = 6;
   localparam logic [IDX_W-1:0] PIX_FIRST    = 6'd54;
   localparam logic [IDX_W-1:0] PIX_GREEN    = 6'd55;
   localparam logic [IDX_W-1:0] PIX_RED      = 6'd56;
   localparam logic [IDX_W-1:0] SEQ_LAST_MAX = 6'd59;
   localparam logic [IDX_W-1:0] HDR_FIRST    = 6'd0;

   localparam logic [31:0] HEADER_BYTES = 32'd54;
   localparam logic [7:0]  INFO_SIZE    = 8'd40;
   localparam logic [7:0]  BITS_PER_PIX = 8'd24;

   typedef struct packed {
      logic [SIDE_W-1:0] width;
      logic [SIDE_W-1:0] height;
      logic [31:0]       image_bytes;
   } geom_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       header;
      logic [1:0] pad;
      logic       image_end;
   } pix_job_type;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v == '0) begin
         r = {{(SIDE_W-1){1'b0}}, 1'b1};
      end else if (v > MAX_SIDE) begin
         r = MAX_SIDE;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                           input geom_type g);
      logic [31:0] file_bytes;
      logic [7:0]  b;
      file_bytes = g.image_bytes + HEADER_BYTES;
      case (idx)
         6'd0:    b = 8'h42;
         6'd1:    b = 8'h4D;
         6'd2:    b = file_bytes[7:0];
         6'd3:    b = file_bytes[15:8];
         6'd4:    b = file_bytes[23:16];
         6'd5:    b = file_bytes[31:24];
         6'd10:   b = HEADER_BYTES[7:0];
         6'd14:   b = INFO_SIZE;
         6'd18:   b = g.width[7:0];
         6'd19:   b = {4'h0, g.width[11:8]};
         6'd22:   b = g.height[7:0];
         6'd23:   b = {4'h0, g.height[11:8]};
         6'd26:   b = 8'd1;
         6'd28:   b = BITS_PER_PIX;
         6'd34:   b = g.image_bytes[7:0];
         6'd35:   b = g.image_bytes[15:8];
         6'd36:   b = g.image_bytes[23:16];
         6'd37:   b = g.image_bytes[31:24];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== src/rgb2bmp_front.sv =====
// front end: accepts pixels, expands channels, tracks column and row, tags header and padding
// depends on rgb2bmp_pkg
`default_nettype none

module rgb2bmp_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [15:0]              req_pixel_word,
   input  wire rgb2bmp_pkg::geom_type    geom,
   input  wire logic                     queue_full,
   output logic                          push,
   output rgb2bmp_pkg::pix_job_type      job
);
   import rgb2bmp_pkg::*;

   logic [COUNT_W-1:0] col_ff, col_in;
   logic [COUNT_W-1:0] row_ff, row_in;
   logic               header_ff, header_in;
   logic [15:0]        sw;
   logic [4:0]         r5, b5;
   logic [5:0]         g6;
   logic               row_end, img_end;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   assign sw = {req_pixel_word[7:0], req_pixel_word[15:8]};
   assign r5 = sw[15:11];
   assign g6 = sw[10:5];
   assign b5 = sw[4:0];

   assign row_end = ({1'b0, col_ff} + 12'd1) >= geom.width;
   assign img_end = row_end && (({1'b0, row_ff} + 12'd1) >= geom.height);

   always_comb begin
      job.blue      = {b5, b5[4:2]};
      job.green     = {g6, g6[5:4]};
      job.red       = {r5, r5[4:2]};
      job.header    = header_ff;
      job.pad       = row_end ? geom.width[1:0] : 2'd0;
      job.image_end = img_end;
   end

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      header_in = header_ff;
      if (push) begin
         header_in = img_end;
         if (row_end) begin
            col_in = '0;
            row_in = img_end ? '0 : row_ff + 11'd1;
         end else begin
            col_in = col_ff + 11'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         header_ff <= 1'b1;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         header_ff <= header_in;
      end
   end

`include "assert_macros.svh"

   `ASSERT_CLK(a_header_after_end, $rose(header_ff) |-> $past(push && img_end), "header rearmed without image end")
   `ASSERT_NEVER(a_row_end_keeps_col, push && row_end && (col_in != '0), "row end left column nonzero")

endmodule

`default_nettype wire

// ===== src/rgb2bmp_queue.sv =====
// short job queue between front and back ends
// depends on rgb2bmp_pkg
`default_nettype none

module rgb2bmp_queue #(
   parameter int unsigned DEPTH = rgb2bmp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire rgb2bmp_pkg::pix_job_type push_job,
   input  wire logic                     pop,
   output logic                          full,
   output logic                          empty,
   output rgb2bmp_pkg::pix_job_type      head
);
   import rgb2bmp_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   pix_job_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`include "assert_macros.svh"

   `ASSERT_NEVER(a_push_full, push && full, "push into full queue")
   `ASSERT_NEVER(a_pop_empty, pop && empty, "pop from empty queue")

endmodule

`default_nettype wire

// ===== src/rgb2bmp_back.sv =====
// back end: walks header, pixel and padding bytes of each job into the output register
// depends on rgb2bmp_pkg
`default_nettype none

module rgb2bmp_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rgb2bmp_pkg::geom_type    geom,
   input  wire logic                     empty,
   input  wire rgb2bmp_pkg::pix_job_type head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_of_run,
   output logic                          rsp_end_of_image
);
   import rgb2bmp_pkg::*;

   logic             rsp_valid_ff;
   logic [7:0]       byte_ff;
   logic             last_ff;
   logic             end_ff;
   logic             active_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] cur_idx;
   logic [IDX_W-1:0] last_idx;
   logic             advance;
   logic             is_last;
   logic [7:0]       byte_in;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_last_of_run  = last_ff;
   assign rsp_end_of_image = end_ff;

   assign cur_idx  = active_ff ? idx_ff : (head.header ? HDR_FIRST : PIX_FIRST);
   assign last_idx = PIX_RED + {4'b0000, head.pad};
   assign advance  = !empty && (!rsp_valid_ff || rsp_ready);
   assign is_last  = (cur_idx == last_idx);
   assign pop      = advance && is_last;

   always_comb begin
      priority if (cur_idx < PIX_FIRST) begin
         byte_in = hdr_byte(cur_idx, geom);
      end else if (cur_idx == PIX_FIRST) begin
         byte_in = head.blue;
      end else if (cur_idx == PIX_GREEN) begin
         byte_in = head.green;
      end else if (cur_idx == PIX_RED) begin
         byte_in = head.red;
      end else begin
         byte_in = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         idx_ff       <= '0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
         active_ff    <= !is_last;
         idx_ff       <= cur_idx + 6'd1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         last_ff <= is_last;
         end_ff  <= is_last && head.image_end;
      end
   end

`include "assert_macros.svh"

   `ASSERT_CLK(a_end_is_last, rsp_valid_ff && end_ff |-> last_ff, "end of image off run end")
   `ASSERT_CLK(a_idx_bound, active_ff |-> idx_ff <= SEQ_LAST_MAX, "byte index past sequence")

endmodule

`default_nettype wire

// ===== src/rgb565_to_bmp24_stream_unit.sv =====
// rgb565 to 24-bit bmp byte stream: register port, geometry and front/queue/back hookup
// first byte goes out via the job queue and the output register; a header pixel gives 57..60 bytes
// a pixel gives 3 bytes plus 0..3 row padding bytes, sent through the one-byte output register
// the front end takes a pixel each cycle until the job queue fills
// synchronous reset: width 800, height 480, counters zero, header armed, queue and output empty
`default_nettype none

module rgb565_to_bmp24_stream_unit #(
   parameter int unsigned QUEUE_DEPTH = rgb2bmp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_pixel_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run,
   output logic             rsp_end_of_image,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import rgb2bmp_pkg::*;

   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   logic [SIDE_W-1:0] width_ff;
   logic [SIDE_W-1:0] height_ff;
   logic [31:0]       image_bytes_ff;
   logic [SIDE_W-1:0] width_eff;
   logic [SIDE_W-1:0] height_eff;
   logic [13:0]       row_sum;
   logic [13:0]       row_bytes;
   logic [25:0]       image_prod;
   logic              csr_wr;
   geom_type          geom;
   logic              push;
   logic              pop;
   logic              full;
   logic              empty;
   pix_job_type       push_job;
   pix_job_type       head;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[SIDE_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[SIDE_W-1:0];
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_IMAGE_WIDTH:  csr_prdata = {20'h00000, width_ff};
         REG_IMAGE_HEIGHT: csr_prdata = {20'h00000, height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign width_eff  = clamp_side(width_ff);
   assign height_eff = clamp_side(height_ff);

   // row is 3*width rounded up to a multiple of 4
   assign row_sum    = {2'b00, width_eff} + {1'b0, width_eff, 1'b0} + 14'd3;
   assign row_bytes  = {row_sum[13:2], 2'b00};
   assign image_prod = row_bytes * height_eff;

   always_ff @(posedge clock) begin
      image_bytes_ff <= {6'b000000, image_prod};
   end

   always_comb begin
      geom.width       = width_eff;
      geom.height      = height_eff;
      geom.image_bytes = image_bytes_ff;
   end

   rgb2bmp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_word (req_pixel_word),
      .geom           (geom),
      .queue_full     (full),
      .push           (push),
      .job            (push_job)
   );

   rgb2bmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   rgb2bmp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .geom             (geom),
      .empty            (empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_image (rsp_end_of_image)
   );

endmodule

`default_nettype wire
